>>> sv/lbb_pkg.sv
`timescale 1ns / 1ps

package lbb_pkg;

  localparam int LABEL_COUNT = 4096;
  localparam int COORD_BITS = 10;
  localparam int LABEL_BITS = 12;
  localparam int ADDR_BITS = $clog2(LABEL_COUNT);
  localparam int EPOCH_BITS = 8;
  localparam int CFG_IDX_BITS = 3;
  localparam int BOX_BITS = 6 * COORD_BITS;
  localparam int ENTRY_BITS = EPOCH_BITS + BOX_BITS;
  localparam int IN_TDATA_BITS = ((LABEL_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((BOX_BITS + 7) / 8) * 8;

  localparam logic CMD_VOXEL = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [EPOCH_BITS-1:0] epoch_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_START = 3'd0,
    CFG_X_END   = 3'd1,
    CFG_Y_START = 3'd2,
    CFG_Y_END   = 3'd3,
    CFG_Z_START = 3'd4,
    CFG_Z_END   = 3'd5
  } cfg_idx_t;

  // Declared high member first so that x_min lands in the lowest bits.
  typedef struct packed {
    coord_t z_max;
    coord_t z_min;
    coord_t y_max;
    coord_t y_min;
    coord_t x_max;
    coord_t x_min;
  } box_t;

  typedef struct packed {
    epoch_t tag;
    box_t   box;
  } entry_t;

  typedef struct packed {
    logic   at_start;
    coord_t x;
    coord_t y;
    coord_t z;
  } scan_pos_t;

endpackage

>>> sv/lbb_ram.sv
`timescale 1ns / 1ps

module lbb_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 68,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/lbb_scan.sv
`timescale 1ns / 1ps

module lbb_scan (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [lbb_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [lbb_pkg::COORD_BITS-1:0]      cfg_wdata,
  input  logic                                advance,
  output lbb_pkg::scan_pos_t                  pos
);

  lbb_pkg::coord_t x_start, x_end, y_start, y_end, z_start, z_end;
  lbb_pkg::coord_t x_start_next, x_end_next, y_start_next, y_end_next;
  lbb_pkg::coord_t z_start_next, z_end_next;
  lbb_pkg::coord_t scan_x, scan_y, scan_z;
  lbb_pkg::coord_t scan_x_next, scan_y_next, scan_z_next;
  logic            cfg_hit;

  always_comb begin
    x_start_next = x_start;
    x_end_next   = x_end;
    y_start_next = y_start;
    y_end_next   = y_end;
    z_start_next = z_start;
    z_end_next   = z_end;
    cfg_hit      = 1'b0;
    if (cfg_wen) begin
      cfg_hit = 1'b1;
      case (lbb_pkg::cfg_idx_t'(cfg_index))
        lbb_pkg::CFG_X_START: x_start_next = cfg_wdata;
        lbb_pkg::CFG_X_END:   x_end_next   = cfg_wdata;
        lbb_pkg::CFG_Y_START: y_start_next = cfg_wdata;
        lbb_pkg::CFG_Y_END:   y_end_next   = cfg_wdata;
        lbb_pkg::CFG_Z_START: z_start_next = cfg_wdata;
        lbb_pkg::CFG_Z_END:   z_end_next   = cfg_wdata;
        default:              cfg_hit      = 1'b0;
      endcase
    end
  end

  // Each axis wraps to its start once it reaches or passes its end; the
  // wrap carries into the next slower axis.
  always_comb begin
    scan_x_next = scan_x;
    scan_y_next = scan_y;
    scan_z_next = scan_z;
    if (scan_x >= x_end) begin
      scan_x_next = x_start;
      if (scan_y >= y_end) begin
        scan_y_next = y_start;
        if (scan_z >= z_end) begin
          scan_z_next = z_start;
        end else begin
          scan_z_next = scan_z + 1'b1;
        end
      end else begin
        scan_y_next = scan_y + 1'b1;
      end
    end else begin
      scan_x_next = scan_x + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_start <= '0;
      x_end   <= lbb_pkg::COORD_BITS'(1023);
      y_start <= '0;
      y_end   <= lbb_pkg::COORD_BITS'(1023);
      z_start <= '0;
      z_end   <= lbb_pkg::COORD_BITS'(1023);
      scan_x  <= '0;
      scan_y  <= '0;
      scan_z  <= '0;
    end else if (cfg_hit) begin
      x_start <= x_start_next;
      x_end   <= x_end_next;
      y_start <= y_start_next;
      y_end   <= y_end_next;
      z_start <= z_start_next;
      z_end   <= z_end_next;
      scan_x  <= x_start_next;
      scan_y  <= y_start_next;
      scan_z  <= z_start_next;
    end else if (advance) begin
      scan_x <= scan_x_next;
      scan_y <= scan_y_next;
      scan_z <= scan_z_next;
    end
  end

  assign pos.at_start = (scan_x == x_start) && (scan_y == y_start) && (scan_z == z_start);
  assign pos.x = scan_x;
  assign pos.y = scan_y;
  assign pos.z = scan_z;

endmodule

>>> sv/label_bounding_box_table_unit.sv
`timescale 1ns / 1ps

// Per-label 3D bounding box table. Voxel labels stream in raster order (x
// fastest) over the configured extent and each one widens the box of its
// label; a query beat returns the found flag in tuser and the six bounds in
// tdata, or zeros when the label has no box in the current frame. The block
// takes one beat per cycle while no clearing pass runs and no query result is
// held back by a stalled output: the box memory is read when a beat is
// accepted and written back the next cycle, with the in-flight write forwarded
// to a back-to-back beat of the same label. A query result goes from the read
// stage into the output register. Frame clears are done by an 8-bit epoch tag
// stored with each entry, so they cost nothing, except that once the tag has
// used up all 255 nonzero values (one frame in 255), the next frame's first
// voxel is held off for a clearing pass of all 4096 memory entries. The same
// pass runs after reset, accepting no beat (configuration writes are taken).
module label_bounding_box_table_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wen,
  input  logic [lbb_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [lbb_pkg::COORD_BITS-1:0]        cfg_wdata,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [lbb_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,  // label, zero pad
  input  logic                                  s_axis_tuser,  // cmd
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // x_min, x_max, y_min, y_max, z_min, z_max, zero pad
  output logic [lbb_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
  output logic                                  m_axis_tuser   // found
);

  typedef enum logic [1:0] {
    ST_SWEEP = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t                            state;
  logic [lbb_pkg::ADDR_BITS-1:0]     sweep_addr;
  lbb_pkg::epoch_t                   epoch;

  lbb_pkg::scan_pos_t                pos;
  logic                              accept;
  logic                              in_cmd;
  logic [lbb_pkg::LABEL_BITS-1:0]    in_label;
  logic [lbb_pkg::ADDR_BITS-1:0]     rd_addr;
  logic                              voxel_start;
  logic                              wrap_block;
  logic                              s1_hold;

  logic                              s1_valid;
  logic                              s1_cmd;
  logic [lbb_pkg::ADDR_BITS-1:0]     s1_addr;
  logic                              s1_in_range;
  lbb_pkg::coord_t                   s1_x, s1_y, s1_z;
  lbb_pkg::epoch_t                   s1_epoch;
  logic                              s1_fwd;
  lbb_pkg::entry_t                   s1_fwd_entry;

  lbb_pkg::entry_t                   rd_data;
  lbb_pkg::entry_t                   cur;
  logic                              hit;
  lbb_pkg::box_t                     upd;

  logic                              wr_en;
  logic [lbb_pkg::ADDR_BITS-1:0]     wr_addr;
  lbb_pkg::entry_t                   wr_entry;

  logic                              out_found;
  lbb_pkg::box_t                     out_box;

  assign in_cmd   = s_axis_tuser;
  assign in_label = s_axis_tdata[lbb_pkg::LABEL_BITS-1:0];
  assign rd_addr  = lbb_pkg::ADDR_BITS'(in_label);

  assign voxel_start = (in_cmd == lbb_pkg::CMD_VOXEL) && pos.at_start;
  // A new frame at the last epoch value needs the memory swept first.
  assign wrap_block  = s_axis_tvalid && voxel_start && (epoch == '1);
  assign s1_hold     = s1_valid && (s1_cmd == lbb_pkg::CMD_QUERY) &&
                       m_axis_tvalid && !m_axis_tready;
  assign s_axis_tready = (state == ST_RUN) && !s1_hold && !wrap_block;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lbb_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .advance   (accept && (in_cmd == lbb_pkg::CMD_VOXEL)),
    .pos       (pos)
  );

  lbb_ram #(
    .DEPTH     (lbb_pkg::LABEL_COUNT),
    .WIDTH     (lbb_pkg::ENTRY_BITS),
    .ADDR_BITS (lbb_pkg::ADDR_BITS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_SWEEP;
      sweep_addr <= '0;
      epoch      <= '0;
    end else begin
      case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_addr == lbb_pkg::ADDR_BITS'(lbb_pkg::LABEL_COUNT - 1)) begin
            state <= ST_RUN;
            epoch <= '0;
          end
        end
        ST_RUN: begin
          if (wrap_block && !(s1_valid && (s1_cmd == lbb_pkg::CMD_VOXEL))) begin
            state      <= ST_SWEEP;
            sweep_addr <= '0;
          end else if (accept && voxel_start) begin
            epoch <= epoch + 1'b1;
          end
        end
        default: state <= ST_SWEEP;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_hold) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd       <= in_cmd;
      s1_addr      <= rd_addr;
      s1_in_range  <= (32'(in_label) < lbb_pkg::LABEL_COUNT);
      s1_x         <= pos.x;
      s1_y         <= pos.y;
      s1_z         <= pos.z;
      s1_epoch     <= voxel_start ? epoch + 1'b1 : epoch;
      // The write leaving this cycle is not yet in the read data.
      s1_fwd       <= wr_en && (wr_addr == rd_addr);
      s1_fwd_entry <= wr_entry;
    end
  end

  always_comb begin
    cur = s1_fwd ? s1_fwd_entry : rd_data;
    hit = s1_in_range && (s1_epoch != '0) && (cur.tag == s1_epoch);
    if (hit) begin
      upd.x_min = (s1_x < cur.box.x_min) ? s1_x : cur.box.x_min;
      upd.x_max = (s1_x > cur.box.x_max) ? s1_x : cur.box.x_max;
      upd.y_min = (s1_y < cur.box.y_min) ? s1_y : cur.box.y_min;
      upd.y_max = (s1_y > cur.box.y_max) ? s1_y : cur.box.y_max;
      upd.z_min = (s1_z < cur.box.z_min) ? s1_z : cur.box.z_min;
      upd.z_max = (s1_z > cur.box.z_max) ? s1_z : cur.box.z_max;
    end else begin
      upd.x_min = s1_x;
      upd.x_max = s1_x;
      upd.y_min = s1_y;
      upd.y_max = s1_y;
      upd.z_min = s1_z;
      upd.z_max = s1_z;
    end
  end

  always_comb begin
    if (state == ST_SWEEP) begin
      wr_en    = 1'b1;
      wr_addr  = sweep_addr;
      wr_entry = '0;
    end else begin
      wr_en        = s1_valid && (s1_cmd == lbb_pkg::CMD_VOXEL) && s1_in_range;
      wr_addr      = s1_addr;
      wr_entry.tag = s1_epoch;
      wr_entry.box = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_valid && (s1_cmd == lbb_pkg::CMD_QUERY) && !s1_hold) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && (s1_cmd == lbb_pkg::CMD_QUERY) && !s1_hold) begin
      out_found <= hit;
      out_box   <= hit ? cur.box : '0;
    end
  end

  assign m_axis_tuser = out_found;
  assign m_axis_tdata = {(lbb_pkg::OUT_TDATA_BITS - lbb_pkg::BOX_BITS)'(0), out_box};

endmodule

>>> sv/lbb_checker.sv
`timescale 1ns / 1ps

module lbb_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_axis_tvalid,
  input logic                                  s_axis_tready,
  input logic                                  m_axis_tvalid,
  input logic                                  m_axis_tready,
  input logic [lbb_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata,
  input logic                                  m_axis_tuser
);

  localparam int CB = lbb_pkg::COORD_BITS;

  // A result beat waits until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  // An absent label reports all-zero bounds.
  a_absent_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("absent label with nonzero bounds");

  // A found box is never inverted on any axis.
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[CB-1:0] <= m_axis_tdata[2*CB-1:CB]) &&
      (m_axis_tdata[3*CB-1:2*CB] <= m_axis_tdata[4*CB-1:3*CB]) &&
      (m_axis_tdata[5*CB-1:4*CB] <= m_axis_tdata[6*CB-1:5*CB]))
    else $error("bounding box with min above max");

  // A fresh result follows an accepted beat through the read stage and the output register.
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result beat without a matching input beat");

  // The memory clearing pass holds off input right after reset.
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !s_axis_tready)
    else $error("input accepted before the clearing pass");

endmodule

bind label_bounding_box_table_unit lbb_checker u_lbb_checker (.*);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_AT_BEAT = 950;
  localparam int HOLD_CYCLES = 300;
  localparam int POOL_SIZE = 6;
  localparam int PHASES = 12;

  typedef logic [LABEL_BITS-1:0] label_t;

  typedef struct packed {
    logic   cmd;
    label_t label;
  } label_beat_t;

  typedef struct packed {
    logic found;
    box_t box;
  } box_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [COORD_BITS-1:0] cfg_wdata = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_BITS-1:0] s_axis_tdata = '0;  // label, zero pad
  logic s_axis_tuser = CMD_VOXEL;               // cmd
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // x_min, x_max, y_min, y_max, z_min, z_max, zero pad
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata;
  logic m_axis_tuser;                           // found

  label_bounding_box_table_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  label_beat_t label_beats[$];
  box_answer_t pending_answers[$];
  int errors = 0;
  int in_beats = 0;
  int send_idle_pct = 25;
  int recv_idle_pct = 59;

  // Shadow of the block: extent, scan position and per-label boxes. Instead of
  // clearing every valid bit at a frame start, an entry counts as present when
  // it was last touched in the current frame.
  coord_t extent_start[3] = '{default: '0};
  coord_t extent_end[3] = '{default: '1};
  coord_t scan[3] = '{default: '0};
  int frame_no = 0;
  int label_frame[LABEL_COUNT] = '{default: -1};
  box_t label_box[LABEL_COUNT];

  task automatic update_boxes(input logic cmd, input label_t label);
    box_answer_t answer;
    box_t b;
    bit carry;
    if (cmd == CMD_QUERY) begin
      answer.found = (label_frame[label] == frame_no);
      answer.box = answer.found ? label_box[label] : '0;
      pending_answers.push_back(answer);
    end else begin
      if (scan[0] == extent_start[0] && scan[1] == extent_start[1] &&
          scan[2] == extent_start[2])
        frame_no++;
      if (label_frame[label] != frame_no) begin
        b = '{z_max: scan[2], z_min: scan[2], y_max: scan[1], y_min: scan[1],
              x_max: scan[0], x_min: scan[0]};
        label_frame[label] = frame_no;
      end else begin
        b = label_box[label];
        if (scan[0] < b.x_min) b.x_min = scan[0];
        if (scan[0] > b.x_max) b.x_max = scan[0];
        if (scan[1] < b.y_min) b.y_min = scan[1];
        if (scan[1] > b.y_max) b.y_max = scan[1];
        if (scan[2] < b.z_min) b.z_min = scan[2];
        if (scan[2] > b.z_max) b.z_max = scan[2];
      end
      label_box[label] = b;
      // Each axis wraps to its start once at or past its end and carries on.
      carry = 1'b1;
      for (int a = 0; a < 3 && carry; a++) begin
        if (scan[a] >= extent_end[a]) begin
          scan[a] = extent_start[a];
        end else begin
          scan[a] = scan[a] + 1'b1;
          carry = 1'b0;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Sender: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin : drive_labels
    label_beat_t item;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (label_beats.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        item = label_beats.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_TDATA_BITS'(item.label);
        s_axis_tuser <= item.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      update_boxes(s_axis_tuser, s_axis_tdata[LABEL_BITS-1:0]);
      in_beats <= in_beats + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off that backs the block up.
  int hold_left = 0;
  bit hold_used = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_used && in_beats >= HOLD_AT_BEAT) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_answers
    box_answer_t want;
    box_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result beat with no query outstanding");
      end else begin
        want = pending_answers.pop_front();
        got = m_axis_tdata[BOX_BITS-1:0];
        check_field("found", int'(m_axis_tuser), int'(want.found));
        check_field("x_min", int'(got.x_min), int'(want.box.x_min));
        check_field("x_max", int'(got.x_max), int'(want.box.x_max));
        check_field("y_min", int'(got.y_min), int'(want.box.y_min));
        check_field("y_max", int'(got.y_max), int'(want.box.y_max));
        check_field("z_min", int'(got.z_min), int'(want.box.z_min));
        check_field("z_max", int'(got.z_max), int'(want.box.z_max));
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** label_bounding_box_table_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_beat(input logic cmd, input label_t label);
    label_beats.push_back('{cmd: cmd, label: label});
  endtask

  // Returns at a falling edge once every beat is taken and every answer is in.
  task automatic wait_drained();
    do @(negedge clk);
    while (label_beats.size() != 0 || s_axis_tvalid || pending_answers.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input coord_t value);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_X_START: extent_start[0] = value;
      CFG_X_END:   extent_end[0] = value;
      CFG_Y_START: extent_start[1] = value;
      CFG_Y_END:   extent_end[1] = value;
      CFG_Z_START: extent_start[2] = value;
      CFG_Z_END:   extent_end[2] = value;
      default: ;
    endcase
    scan = extent_start;
  endtask

  task automatic set_extent(input coord_t xs, xe, ys, ye, zs, ze);
    write_reg(CFG_X_START, xs);
    write_reg(CFG_X_END, xe);
    write_reg(CFG_Y_START, ys);
    write_reg(CFG_Y_END, ye);
    write_reg(CFG_Z_START, zs);
    write_reg(CFG_Z_END, ze);
    @(posedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // Mostly a short axis just above its start; now and then an arbitrary end,
  // which may fall below the start.
  function automatic coord_t pick_end(input coord_t start);
    int e;
    if ($urandom_range(0, 7) == 0) return coord_t'($urandom_range(0, 1023));
    e = start + $urandom_range(0, 5);
    return (e > 1023) ? coord_t'(1023) : coord_t'(e);
  endfunction

  initial begin : stimulus
    coord_t xs, xe, ys, ye, zs, ze;
    label_t pool[POOL_SIZE];
    int r;
    int count;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset extent: the scan runs along the first row from x = 0.
    push_beat(CMD_QUERY, 12'd0);
    push_beat(CMD_VOXEL, 12'd4095);
    push_beat(CMD_VOXEL, 12'd4095);
    push_beat(CMD_VOXEL, 12'd0);
    push_beat(CMD_VOXEL, 12'd4095);
    push_beat(CMD_QUERY, 12'd4095);
    push_beat(CMD_QUERY, 12'd0);
    push_beat(CMD_QUERY, 12'd2730);
    push_beat(CMD_QUERY, 12'd1365);
    push_beat(CMD_VOXEL, 12'd1365);
    push_beat(CMD_QUERY, 12'd1365);
    push_beat(CMD_VOXEL, 12'd0);
    push_beat(CMD_QUERY, 12'd0);
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = (i % 2) ? 12'd4095 : 12'd0;

    for (int p = 1; p <= PHASES; p++) begin
      wait_drained();
      if (p == 5) begin
        send_idle_pct = 59;
        recv_idle_pct = 25;
      end else if (p == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        1:  {xs, xe, ys, ye, zs, ze} = {10'd0, 10'd3, 10'd0, 10'd2, 10'd0, 10'd1};
        2:  {xs, xe, ys, ye, zs, ze} = {10'd1020, 10'd1023, 10'd1021, 10'd1023,
                                        10'd1022, 10'd1023};
        3:  {xs, xe, ys, ye, zs, ze} = {10'd5, 10'd2, 10'd9, 10'd11, 10'd7, 10'd7};
        4:  {xs, xe, ys, ye, zs, ze} = {10'd0, 10'd1023, 10'd0, 10'd1023,
                                        10'd0, 10'd1023};
        6:  {xs, xe, ys, ye, zs, ze} = '0;
        7:  {xs, xe, ys, ye, zs, ze} = {10'd682, 10'd685, 10'd341, 10'd343,
                                        10'd1023, 10'd0};
        9:  {xs, xe, ys, ye, zs, ze} = {10'd3, 10'd1, 10'd1023, 10'd1023, 10'd2, 10'd4};
        11: {xs, xe, ys, ye, zs, ze} = {10'd0, 10'd1, 10'd0, 10'd1, 10'd0, 10'd1};
        default: begin
          xs = coord_t'($urandom_range(0, 1023));
          ys = coord_t'($urandom_range(0, 1023));
          zs = coord_t'($urandom_range(0, 1023));
          xe = pick_end(xs);
          ye = pick_end(ys);
          ze = pick_end(zs);
        end
      endcase
      set_extent(xs, xe, ys, ye, zs, ze);

      // Boxes of the last frame stay visible until the new frame's first voxel.
      push_beat(CMD_QUERY, pool[0]);
      for (int i = 0; i < POOL_SIZE; i++)
        pool[i] = label_t'($urandom_range(0, LABEL_COUNT - 1));
      // A one-voxel frame turns over a frame per voxel, so it gets a long run.
      count = (p == 6) ? 300 : 70;
      repeat (count) begin
        r = $urandom_range(0, 99);
        if (r < 68)
          push_beat(CMD_VOXEL, pool[$urandom_range(0, POOL_SIZE - 1)]);
        else if (r < 75)
          push_beat(CMD_VOXEL, label_t'($urandom_range(0, LABEL_COUNT - 1)));
        else if (r < 93)
          push_beat(CMD_QUERY, pool[$urandom_range(0, POOL_SIZE - 1)]);
        else
          push_beat(CMD_QUERY, label_t'($urandom_range(0, LABEL_COUNT - 1)));
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("** label_bounding_box_table_unit: PASSED **");
    end else begin
      $display("** label_bounding_box_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
sv/lbb_pkg.sv
sv/lbb_ram.sv
sv/lbb_scan.sv
sv/label_bounding_box_table_unit.sv
sv/lbb_checker.sv
verif/tb_top.sv
